[rtl/mcw_pkg.sv]
// Shared types, codes and constants of the multi-channel watchdog.
`timescale 1ns / 1ps

package mcw_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 16;
   localparam int MAX_RESULTS          = 16;
   localparam int FOUND_W              = 5;
   localparam int CHAN_OUT_W           = 4;
   localparam int TIME_W               = 32;

   typedef enum logic [1:0] {
      ACT_TICK     = 2'd0,
      ACT_REGISTER = 2'd1,
      ACT_KICK     = 2'd2,
      ACT_SCAN     = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_FULL        = 3'd1,
      ST_BAD_CHANNEL = 3'd2,
      ST_TIMED_OUT   = 3'd3,
      ST_NONE        = 3'd4
   } status_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_SCAN
   } state_type;

   typedef struct packed {
      action_type         action;
      logic [7:0]         channel;
      logic [TIME_W-1:0]  timeout_ms;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [CHAN_OUT_W-1:0]  channel_out;
      logic [TIME_W-1:0]      elapsed_ms;
      logic                   last;
   } rsp_type;

endpackage

[rtl/mcw_table.sv]
// Channel table: last-kick and timeout memories, one write and one read port.
`timescale 1ns / 1ps

module mcw_table #(
   parameter int NUM_CHANNELS = mcw_pkg::NUM_CHANNELS_DEFAULT,
   parameter int IDX_W        = 4
) (
   input  logic                      clock,
   input  logic                      wr_kick_en,
   input  logic                      wr_tmo_en,
   input  logic [IDX_W-1:0]          wr_addr,
   input  logic [mcw_pkg::TIME_W-1:0] wr_kick,
   input  logic [mcw_pkg::TIME_W-1:0] wr_tmo,
   input  logic                      rd_en,
   input  logic [IDX_W-1:0]          rd_addr,
   output logic [mcw_pkg::TIME_W-1:0] rd_kick,
   output logic [mcw_pkg::TIME_W-1:0] rd_tmo
);
   import mcw_pkg::*;

   logic [TIME_W-1:0] kick_mem [NUM_CHANNELS];
   logic [TIME_W-1:0] tmo_mem  [NUM_CHANNELS];
   logic [TIME_W-1:0] rd_kick_ff;
   logic [TIME_W-1:0] rd_tmo_ff;

   always_ff @(posedge clock) begin
      if (wr_kick_en) begin
         kick_mem[wr_addr] <= wr_kick;
      end
      if (wr_tmo_en) begin
         tmo_mem[wr_addr] <= wr_tmo;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_kick_ff <= kick_mem[rd_addr];
         rd_tmo_ff  <= tmo_mem[rd_addr];
      end
   end

   assign rd_kick = rd_kick_ff;
   assign rd_tmo  = rd_tmo_ff;

endmodule

[rtl/multi_channel_watchdog_core.sv]
// Top level of the multi-channel watchdog: command decode, scan sequencer, result register.
`timescale 1ns / 1ps
//
//  channel | ports                          | direction | item
//  --------+--------------------------------+-----------+-------------------------------
//  request | req_valid req_stall req_data   | in        | action, channel, timeout_ms
//  result  | rsp_valid rsp_stall rsp_data   | out       | status, channel_out, elapsed_ms, last
//
//  Tick, register and kick are each done at the accepting edge; register and kick
//  leave their result in the output register at that edge.
//  A scan reads the table memory at one entry per cycle while no timeout result
//  is stalled; read data is registered, and the scan closes out after the last compare.
//  Reset is synchronous and clears time, channel count and control; the table
//  memories are not cleared, only registered entries are ever read.
//  A stalled result holds the output register; a scan then holds its read and
//  compare stage on a hit while a timeout result is pending, until that result can move on.
//  One item is worked at a time: req_stall is high during a scan and while
//  the output register holds a result that is stalled.

module multi_channel_watchdog_core #(
   parameter int NUM_CHANNELS = mcw_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mcw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mcw_pkg::rsp_type rsp_data
);
   import mcw_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int UW    = $clog2(NUM_CHANNELS + 1);

   // control state
   state_type            state_ff, state_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [UW-1:0]        used_ff, used_in;
   logic [UW-1:0]        scan_idx_ff, scan_idx_in;
   logic [FOUND_W-1:0]   found_ff, found_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic [CHAN_OUT_W-1:0] pend_chan_ff, pend_chan_in;
   logic [TIME_W-1:0]     pend_elapsed_ff, pend_elapsed_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // table ports
   logic              wr_kick_en, wr_tmo_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [TIME_W-1:0] rd_kick, rd_tmo;

   logic              out_free, req_accept, load_out;
   logic              hit, consume, more;
   logic [TIME_W-1:0] elapsed;

   mcw_table #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .IDX_W        (IDX_W)
   ) u_table (
      .clock      (clock),
      .wr_kick_en (wr_kick_en),
      .wr_tmo_en  (wr_tmo_en),
      .wr_addr    (wr_addr),
      .wr_kick    (now_ff),
      .wr_tmo     (req_data.timeout_ms),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_kick    (rd_kick),
      .rd_tmo     (rd_tmo)
   );

   // output register may take a new result this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != FSM_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   // compare stage: elapsed time modulo 2^32 against the channel timeout
   assign elapsed = now_ff - rd_kick;
   assign hit     = elapsed > rd_tmo;

   always_comb begin
      state_in        = state_ff;
      now_in          = now_ff;
      used_in         = used_ff;
      scan_idx_in     = scan_idx_ff;
      found_in        = found_ff;
      chk_valid_in    = chk_valid_ff;
      chk_idx_in      = chk_idx_ff;
      pend_valid_in   = pend_valid_ff;
      pend_chan_in    = pend_chan_ff;
      pend_elapsed_in = pend_elapsed_ff;
      load_out        = 1'b0;
      rsp_data_in     = rsp_data_ff;
      wr_kick_en      = 1'b0;
      wr_tmo_en       = 1'b0;
      wr_addr         = used_ff[IDX_W-1:0];
      rd_en           = 1'b0;
      rd_addr         = scan_idx_ff[IDX_W-1:0];
      consume         = 1'b0;
      more            = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               case (req_data.action)
                  ACT_TICK: begin
                     now_in = now_ff + 1'b1;
                  end
                  ACT_REGISTER: begin
                     load_out = 1'b1;
                     if (used_ff >= UW'(NUM_CHANNELS)) begin
                        rsp_data_in = '{ST_FULL, '0, '0, 1'b1};
                     end else begin
                        wr_kick_en  = 1'b1;
                        wr_tmo_en   = 1'b1;
                        rsp_data_in = '{ST_OK, CHAN_OUT_W'(used_ff), '0, 1'b1};
                        used_in     = used_ff + 1'b1;
                     end
                  end
                  ACT_KICK: begin
                     load_out = 1'b1;
                     if (9'(req_data.channel) >= 9'(used_ff)) begin
                        rsp_data_in = '{ST_BAD_CHANNEL, '0, '0, 1'b1};
                     end else begin
                        wr_kick_en  = 1'b1;
                        wr_addr     = req_data.channel[IDX_W-1:0];
                        rsp_data_in = '{ST_OK, req_data.channel[CHAN_OUT_W-1:0], '0, 1'b1};
                     end
                  end
                  ACT_SCAN: begin
                     state_in      = FSM_SCAN;
                     scan_idx_in   = '0;
                     found_in      = '0;
                     chk_valid_in  = 1'b0;
                     pend_valid_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         FSM_SCAN: begin
            // a hit pushes the previous pending result out, so it needs room
            consume = chk_valid_ff && !(hit && pend_valid_ff && !out_free);
            if (consume) begin
               chk_valid_in = 1'b0;
               if (hit) begin
                  if (pend_valid_ff) begin
                     load_out    = 1'b1;
                     rsp_data_in = '{ST_TIMED_OUT, pend_chan_ff, pend_elapsed_ff, 1'b0};
                  end
                  pend_valid_in   = 1'b1;
                  pend_chan_in    = CHAN_OUT_W'(chk_idx_ff);
                  pend_elapsed_in = elapsed;
                  found_in        = found_ff + 1'b1;
               end
            end

            // stop issuing reads at the end of the table or at the result cap
            more = (scan_idx_ff < used_ff) && (found_in < FOUND_W'(MAX_RESULTS));

            if ((!chk_valid_ff || consume) && more) begin
               rd_en        = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = scan_idx_ff[IDX_W-1:0];
               scan_idx_in  = scan_idx_ff + 1'b1;
            end else if (!chk_valid_ff && !more && out_free) begin
               // close out: mark the held result last, or report none
               load_out = 1'b1;
               if (pend_valid_ff) begin
                  rsp_data_in = '{ST_TIMED_OUT, pend_chan_ff, pend_elapsed_ff, 1'b1};
               end else begin
                  rsp_data_in = '{ST_NONE, '0, '0, 1'b1};
               end
               pend_valid_in = 1'b0;
               state_in      = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         now_ff        <= '0;
         used_ff       <= '0;
         scan_idx_ff   <= '0;
         found_ff      <= '0;
         chk_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         used_ff       <= used_in;
         scan_idx_ff   <= scan_idx_in;
         found_ff      <= found_in;
         chk_valid_ff  <= chk_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff      <= chk_idx_in;
      pend_chan_ff    <= pend_chan_in;
      pend_elapsed_ff <= pend_elapsed_in;
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no read in flight and no held result outside a scan
   a_idle_clean : assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_IDLE) |-> (!chk_valid_ff && !pend_valid_ff))
      else $error("scan state left behind in idle");

   // channel count never passes the table size
   a_used_bound : assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(NUM_CHANNELS))
      else $error("channel count exceeds table size");

   // a scan never reports more than the result cap
   a_found_bound : assert property (@(posedge clock) disable iff (reset)
      found_ff <= FOUND_W'(MAX_RESULTS))
      else $error("scan result count exceeds cap");

   // a result is never overwritten while it is stalled
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load_out)
      else $error("stalled result overwritten");

endmodule
